### design/mrc_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus RTU reply checker.
// No dependencies.
package mrc_pkg;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [3:0]  CountMax = 4'd15;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_OK    = 2'd1,
    ST_CRC_ERR   = 2'd2,
    ST_FRAME_ERR = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  frame_length;
    logic [15:0] reg_value;
  } res_t;

  function automatic logic [15:0] crc_absorb(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/modbus_rtu_response_checker_unit.sv
// Top level of the Modbus RTU reply checker: input register, frame check, result register.
// Depends on mrc_pkg and mrc_frame_check.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one reply byte per request in rx_byte,
//   with end_of_frame set on the final byte of the frame.
//   Output channel (out_valid / out_stall) carries one result per frame: status,
//   frame_length and reg_value (frame bytes 3 and 4, high then low).
//   Bytes without end_of_frame produce no result.
//   A final byte waits in the input register, then its result in the result register.
//   Throughput: one byte per cycle unless in_stall is high; the CRC step for a byte is
//   eight bit-steps of combinational logic from delay1 and the running CRC register.
//   Stall: a held result blocks only a following final byte; mid-frame bytes keep
//   flowing into the frame state while the result waits.
//   Reset (rst, synchronous) empties both registers and restarts the frame.
module modbus_rtu_response_checker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  frame_length,
  output logic [15:0] reg_value
);
  import mrc_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eof;
  logic       out_full;
  res_t       out_res;
  res_t       res;
  logic       step;

  assign step     = in_full && (!in_eof || !out_full || !out_stall);
  assign in_stall = in_full && !step;

  mrc_frame_check u_check (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (in_byte),
    .end_of_frame (in_eof),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
      in_eof  <= end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (step && in_eof) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_eof) begin
      out_res <= res;
    end
  end

  assign out_valid    = out_full;
  assign status       = out_res.status;
  assign frame_length = out_res.frame_length;
  assign reg_value    = out_res.reg_value;

`ifndef SYNTHESIS
  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && in_eof))
    else $error("input stalled without a held result ahead of a final byte");

  a_bad_length_frame_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_length < 4'd5 || frame_length > 4'd8))
      |-> (status == ST_FRAME_ERR))
    else $error("length outside 5..8 without frame error");

  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> (frame_length == 4'd7 || frame_length == 4'd8))
    else $error("ok status with wrong length");

  a_not_ok_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NOT_OK) |-> (frame_length == 4'd5 || frame_length == 4'd6))
    else $error("not_ok status with wrong length");

  a_result_from_final_byte: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(step && in_eof))
    else $error("result appeared without a final byte");
`endif

endmodule

### design/mrc_frame_check.sv
// Per-frame state (count, delay line, running CRC, data bytes) and end-of-frame status.
// Depends on mrc_pkg.
module mrc_frame_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  input  logic          end_of_frame,
  output mrc_pkg::res_t res
);
  import mrc_pkg::*;

  logic [3:0]  byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  delay0, delay1;
  logic [7:0]  data_high_byte, data_high_byte_next;
  logic [7:0]  data_low_byte, data_low_byte_next;
  logic [15:0] rx_crc;
  logic        len_ok;

  always_comb begin
    running_crc_next    = (byte_count >= 4'd2) ? crc_absorb(running_crc, delay1) : running_crc;
    byte_count_next     = (byte_count != CountMax) ? byte_count + 4'd1 : CountMax;
    data_high_byte_next = (byte_count == 4'd3) ? rx_byte : data_high_byte;
    data_low_byte_next  = (byte_count == 4'd4) ? rx_byte : data_low_byte;
    rx_crc              = {rx_byte, delay0};
    len_ok              = (byte_count_next >= 4'd5) && (byte_count_next <= 4'd8);

    res.frame_length = byte_count_next;
    res.reg_value    = {data_high_byte_next, data_low_byte_next};
    if (!len_ok) begin
      res.status = ST_FRAME_ERR;
    end else if (rx_crc != running_crc_next) begin
      res.status = ST_CRC_ERR;
    end else if (byte_count_next >= 4'd7) begin
      res.status = ST_OK;
    end else begin
      res.status = ST_NOT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_frame)) begin
      byte_count     <= '0;
      running_crc    <= CrcInit;
      delay0         <= '0;
      delay1         <= '0;
      data_high_byte <= '0;
      data_low_byte  <= '0;
    end else if (step) begin
      byte_count     <= byte_count_next;
      running_crc    <= running_crc_next;
      delay0         <= rx_byte;
      delay1         <= delay0;
      data_high_byte <= data_high_byte_next;
      data_low_byte  <= data_low_byte_next;
    end
  end

endmodule
